// ===== hw/rtl/chp_pkg.sv =====
// shared types and constants of the chroma histogram pixel classifier
`timescale 1ns / 1ps
package chp_pkg;

    localparam int PIX_BITS      = 8;
    localparam int SUM_BITS      = PIX_BITS + 2;
    localparam int BIN_BITS      = 4;
    localparam int BINS_PER_AXIS = 1 << BIN_BITS;
    localparam int CELL_BITS     = 2 * BIN_BITS;
    localparam int CELL_COUNT    = 1 << CELL_BITS;
    localparam int STEP_BITS     = $clog2(BIN_BITS);
    localparam int COUNT_BITS    = 32;

    // foreground test: FG_NUM * cell > 7 * count^2, count below 2^SQ_IN_BITS
    localparam int FG_NUM_BITS   = 20;
    localparam logic [FG_NUM_BITS-1:0] FG_NUM = FG_NUM_BITS'(650250);
    localparam int SQ_IN_BITS    = 30;
    localparam int SQ_BITS       = 2 * SQ_IN_BITS;
    localparam int PROD_BITS     = COUNT_BITS + FG_NUM_BITS;
    localparam int RHS_BITS      = SQ_BITS + 3;
    localparam int CMP_BITS      = (PROD_BITS > RHS_BITS) ? PROD_BITS : RHS_BITS;

    localparam int FIFO_DEPTH    = 2;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    localparam logic REQ_TRAIN    = 1'b0;
    localparam logic REQ_CLASSIFY = 1'b1;

    typedef struct packed {
        logic                req_type;
        logic                region_start;
        logic [BIN_BITS-1:0] red_bin;
        logic [BIN_BITS-1:0] blue_bin;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_status;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_DONE
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_MUL
    } t_back_state;

endpackage

// ===== hw/rtl/chp_front.sv =====
// front end: takes a pixel and finds its red and blue chromaticity bins
`timescale 1ns / 1ps
module chp_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_req_type,
    input  logic                         i_region_start,
    input  logic [chp_pkg::PIX_BITS-1:0] i_red,
    input  logic [chp_pkg::PIX_BITS-1:0] i_green,
    input  logic [chp_pkg::PIX_BITS-1:0] i_blue,
    output logic                         o_push,
    output chp_pkg::t_item               o_item,
    input  chp_pkg::t_fifo_status        i_fifo
);

    chp_pkg::t_front_state r_state, n_state;

    logic [chp_pkg::SUM_BITS-1:0]  r_sum;
    logic [chp_pkg::SUM_BITS-1:0]  r_rem_r, n_rem_r;
    logic [chp_pkg::SUM_BITS-1:0]  r_rem_b, n_rem_b;
    logic [chp_pkg::BIN_BITS-1:0]  r_q_r, r_q_b;
    logic [chp_pkg::STEP_BITS-1:0] r_step;
    logic                          r_zero, r_full_r, r_full_b;
    logic                          r_req_type, r_region_start;

    logic [chp_pkg::SUM_BITS:0]    rem2_r, rem2_b, sum_ext;
    logic                          ge_r, ge_b;
    logic [chp_pkg::SUM_BITS-1:0]  in_sum;
    logic                          take, step_en, last_step;

    assign in_sum = chp_pkg::SUM_BITS'(i_red) + chp_pkg::SUM_BITS'(i_green)
                  + chp_pkg::SUM_BITS'(i_blue);

    // one quotient bit per cycle for each channel, remainder stays below the sum unless the channel is the whole sum
    assign sum_ext = {1'b0, r_sum};
    assign rem2_r  = {r_rem_r, 1'b0};
    assign rem2_b  = {r_rem_b, 1'b0};
    assign ge_r    = (rem2_r >= sum_ext);
    assign ge_b    = (rem2_b >= sum_ext);
    assign n_rem_r = ge_r ? chp_pkg::SUM_BITS'(rem2_r - sum_ext) : rem2_r[chp_pkg::SUM_BITS-1:0];
    assign n_rem_b = ge_b ? chp_pkg::SUM_BITS'(rem2_b - sum_ext) : rem2_b[chp_pkg::SUM_BITS-1:0];

    assign last_step = (r_step == chp_pkg::STEP_BITS'(chp_pkg::BIN_BITS - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            chp_pkg::F_IDLE: if (i_valid) n_state = chp_pkg::F_DIV;
            chp_pkg::F_DIV:  if (last_step) n_state = chp_pkg::F_DONE;
            chp_pkg::F_DONE: if (!i_fifo.full) n_state = chp_pkg::F_IDLE;
            default:         n_state = chp_pkg::F_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        step_en = 1'b0;
        o_push  = 1'b0;
        unique case (r_state)
            chp_pkg::F_IDLE: o_ready = 1'b1;
            chp_pkg::F_DIV:  step_en = 1'b1;
            chp_pkg::F_DONE: o_push  = !i_fifo.full;
            default:         o_ready = 1'b0;
        endcase
    end

    assign take = o_ready && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= chp_pkg::F_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (take) begin
                r_step <= '0;
            end else if (step_en) begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_sum          <= in_sum;
            r_rem_r        <= chp_pkg::SUM_BITS'(i_red);
            r_rem_b        <= chp_pkg::SUM_BITS'(i_blue);
            r_zero         <= (in_sum == '0);
            r_full_r       <= (chp_pkg::SUM_BITS'(i_red) == in_sum);
            r_full_b       <= (chp_pkg::SUM_BITS'(i_blue) == in_sum);
            r_req_type     <= i_req_type;
            r_region_start <= i_region_start;
            r_q_r          <= '0;
            r_q_b          <= '0;
        end else if (step_en) begin
            r_rem_r <= n_rem_r;
            r_rem_b <= n_rem_b;
            r_q_r   <= {r_q_r[chp_pkg::BIN_BITS-2:0], ge_r};
            r_q_b   <= {r_q_b[chp_pkg::BIN_BITS-2:0], ge_b};
        end
    end

    // black pixel lands in bin zero, a lone channel clamps to the top bin
    always_comb begin
        o_item.req_type     = r_req_type;
        o_item.region_start = r_region_start;
        priority if (r_zero) begin
            o_item.red_bin  = '0;
            o_item.blue_bin = '0;
        end else begin
            o_item.red_bin  = r_full_r ? '1 : r_q_r;
            o_item.blue_bin = r_full_b ? '1 : r_q_b;
        end
    end

endmodule

// ===== hw/rtl/chp_fifo.sv =====
// short queue of binned pixels between the front and back ends
`timescale 1ns / 1ps
module chp_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  chp_pkg::t_item        i_item,
    input  logic                  i_pop,
    output chp_pkg::t_item        o_item,
    output chp_pkg::t_fifo_status o_status
);

    chp_pkg::t_item                    r_slot [chp_pkg::FIFO_DEPTH];
    logic [chp_pkg::FIFO_PTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [chp_pkg::FIFO_CNT_BITS-1:0] r_count;

    function automatic logic [chp_pkg::FIFO_PTR_BITS-1:0] ptr_inc(
        input logic [chp_pkg::FIFO_PTR_BITS-1:0] p
    );
        return (p == chp_pkg::FIFO_PTR_BITS'(chp_pkg::FIFO_DEPTH - 1))
               ? '0 : p + 1'b1;
    endfunction

    assign o_status.full  = (r_count == chp_pkg::FIFO_CNT_BITS'(chp_pkg::FIFO_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_item         = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= ptr_inc(r_wr_ptr);
            if (i_pop)  r_rd_ptr <= ptr_inc(r_rd_ptr);
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wr_ptr] <= i_item;
    end

endmodule

// ===== hw/rtl/chp_back.sv =====
// back end: histogram update, foreground test and result register
`timescale 1ns / 1ps
module chp_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  chp_pkg::t_item               i_item,
    input  chp_pkg::t_fifo_status        i_fifo,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_foreground,
    output logic [chp_pkg::BIN_BITS-1:0] o_red_bin,
    output logic [chp_pkg::BIN_BITS-1:0] o_blue_bin
);

    chp_pkg::t_back_state r_state, n_state;

    logic [chp_pkg::COUNT_BITS-1:0] r_mem [chp_pkg::CELL_COUNT];
    logic [chp_pkg::CELL_COUNT-1:0] r_cell_valid;
    logic [chp_pkg::COUNT_BITS-1:0] r_rd_data;
    logic                           r_rd_hit;
    chp_pkg::t_item                 r_item;
    logic [chp_pkg::COUNT_BITS-1:0] r_region_cnt;

    logic [chp_pkg::PROD_BITS-1:0]  r_prod;
    logic [chp_pkg::SQ_BITS-1:0]    r_sq;
    logic                           r_cnt_big;

    logic                           r_out_valid, r_out_fg;
    logic [chp_pkg::BIN_BITS-1:0]   r_out_rbin, r_out_bbin;

    logic [chp_pkg::CELL_BITS-1:0]  in_cell, cur_cell;
    logic [chp_pkg::COUNT_BITS-1:0] cell_val, cell_inc, region_inc;
    logic [chp_pkg::RHS_BITS-1:0]   rhs;
    logic                           fg;
    logic                           out_free, is_train;
    logic                           wr_en, mul_en, load_out;

    assign in_cell  = {i_item.blue_bin, i_item.red_bin};
    assign cur_cell = {r_item.blue_bin, r_item.red_bin};
    assign is_train = (r_item.req_type == chp_pkg::REQ_TRAIN);
    assign out_free = !r_out_valid || i_ready;

    // a cell never written since reset reads as zero
    assign cell_val   = r_rd_hit ? r_rd_data : '0;
    assign cell_inc   = (cell_val == '1) ? cell_val : cell_val + 1'b1;
    assign region_inc = (r_region_cnt == '1) ? r_region_cnt : r_region_cnt + 1'b1;

    assign rhs = {r_sq, 3'b000} - chp_pkg::RHS_BITS'(r_sq);
    assign fg  = !r_cnt_big
              && (chp_pkg::CMP_BITS'(r_prod) > chp_pkg::CMP_BITS'(rhs));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            chp_pkg::B_IDLE: if (!i_fifo.empty) n_state = chp_pkg::B_READ;
            chp_pkg::B_READ: begin
                if (!is_train)     n_state = chp_pkg::B_MUL;
                else if (out_free) n_state = chp_pkg::B_IDLE;
            end
            chp_pkg::B_MUL:  if (out_free) n_state = chp_pkg::B_IDLE;
            default:         n_state = chp_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = 1'b0;
        wr_en    = 1'b0;
        mul_en   = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            chp_pkg::B_IDLE: o_pop = !i_fifo.empty;
            chp_pkg::B_READ: begin
                wr_en    = is_train && out_free;
                load_out = is_train && out_free;
                mul_en   = !is_train;
            end
            chp_pkg::B_MUL:  load_out = out_free;
            default:         o_pop = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= chp_pkg::B_IDLE;
            r_cell_valid <= '0;
            r_region_cnt <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (wr_en) begin
                r_cell_valid[cur_cell] <= 1'b1;
                r_region_cnt <= r_item.region_start
                              ? chp_pkg::COUNT_BITS'(1) : region_inc;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // histogram store with registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[cur_cell] <= cell_inc;
        if (o_pop) begin
            r_rd_data <= r_mem[in_cell];
            r_rd_hit  <= r_cell_valid[in_cell];
            r_item    <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod    <= cell_val * chp_pkg::FG_NUM;
            r_sq      <= r_region_cnt[chp_pkg::SQ_IN_BITS-1:0]
                       * r_region_cnt[chp_pkg::SQ_IN_BITS-1:0];
            r_cnt_big <= (r_region_cnt[chp_pkg::COUNT_BITS-1:chp_pkg::SQ_IN_BITS] != '0);
        end
        if (load_out) begin
            r_out_fg   <= (r_state == chp_pkg::B_MUL) ? fg : 1'b0;
            r_out_rbin <= r_item.red_bin;
            r_out_bbin <= r_item.blue_bin;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_foreground = r_out_fg;
    assign o_red_bin    = r_out_rbin;
    assign o_blue_bin   = r_out_bbin;

endmodule

// ===== hw/rtl/chroma_histogram_pixel_classifier.sv =====
// top level of the chroma histogram pixel classifier
`timescale 1ns / 1ps
// usage
//   slave channel: one RGB pixel per word, tuser says training or classify and
//   marks the first training pixel of a region. master channel: one result word
//   per pixel, carrying the red and blue chromaticity bins and, for classify
//   pixels, the foreground flag (zero for training pixels).
// timing
//   the front end finds both bins with a bit-serial divider, one quotient bit
//   per cycle, and takes a new pixel only after the last one is pushed; that
//   divider sets the rate. the back end reads the histogram (registered read),
//   then updates it or runs the registered foreground multiply.
// reset
//   synchronous, active low; histogram valid bits and the region count clear at
//   once, so every bin reads as zero straight after reset.
// stalls
//   results sit in an output register; while the receiver stalls, the back end
//   holds and the 2-deep queue fills, after which the front end stops taking
//   pixels. no word is dropped or repeated.
module chroma_histogram_pixel_classifier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // red[7:0], green[15:8], blue[23:16]
    input  logic [1:0]  i_s_tuser,   // req_type[0], region_start[1]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata    // foreground[0], red_bin[4:1], blue_bin[8:5], zero
);

    chp_pkg::t_item        front_item, queue_item;
    chp_pkg::t_fifo_status queue_status;
    logic                  push, pop;
    logic                  fg;
    logic [chp_pkg::BIN_BITS-1:0] red_bin, blue_bin;

    chp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_s_tvalid),
        .o_ready        (o_s_tready),
        .i_req_type     (i_s_tuser[0]),
        .i_region_start (i_s_tuser[1]),
        .i_red          (i_s_tdata[7:0]),
        .i_green        (i_s_tdata[15:8]),
        .i_blue         (i_s_tdata[23:16]),
        .o_push         (push),
        .o_item         (front_item),
        .i_fifo         (queue_status)
    );

    chp_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (front_item),
        .i_pop    (pop),
        .o_item   (queue_item),
        .o_status (queue_status)
    );

    chp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (queue_item),
        .i_fifo       (queue_status),
        .o_pop        (pop),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_foreground (fg),
        .o_red_bin    (red_bin),
        .o_blue_bin   (blue_bin)
    );

    // result word, zero padded to two bytes
    assign o_m_tdata = {7'b0, blue_bin, red_bin, fg};

    // queue never overfilled by the front end
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !queue_status.full)
        else $error("push into full queue");

    // back end never takes from an empty queue
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !queue_status.empty)
        else $error("pop from empty queue");

    // front end busy dividing right after it takes a pixel
    a_front_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("pixel accepted while divider busy");

endmodule
